// ----- rtl/pi_fan_drive_antiwindup_unit_macros.svh -----
// Assertion macros shared by the checker file of the fan drive block.
`ifndef PI_FAN_DRIVE_ANTIWINDUP_UNIT_MACROS_SVH
`define PI_FAN_DRIVE_ANTIWINDUP_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfd assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfd assertion failed");

`endif

// ----- rtl/pfd_pkg.sv -----
// Package with the widths, constants and control types of the fan drive block.
package pfd_pkg;

  localparam int TEMP_W     = 15;
  localparam int SETP_W     = 16;
  localparam int GAIN_W     = 7;
  localparam int IDIV_W     = 8;
  localparam int DRIVE_W    = 8;
  localparam int DIFF_W     = 17;
  localparam int INTEG_W    = 24;
  localparam int SUM_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_STEPS  = INTEG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_DIVISOR = 2'd2;

  localparam logic signed [SETP_W-1:0] SETPOINT_RESET         = 16'sd2300;
  localparam logic [GAIN_W-1:0]        PROP_GAIN_RESET        = 7'd2;
  localparam logic [IDIV_W-1:0]        INTEGRAL_DIVISOR_RESET = 8'd20;

  localparam logic [IDIV_W-1:0]       INTEG_DIV  = 8'd255;
  localparam logic signed [SUM_W-1:0] DRIVE_MAX  = 25'sd255;
  localparam logic signed [SUM_W-1:0] INTEG_HIGH = 25'sd65535;
  localparam logic signed [SUM_W-1:0] INTEG_LOW  = -25'sd8388608;

  // The reciprocal of 255 scaled by 2^32 and rounded up gives an exact quotient
  // for any 24-bit dividend.
  localparam int                 RECIP_W     = 25;
  localparam int                 RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] INTEG_RECIP = 25'd16843010;

  typedef struct packed {
    logic load;
    logic mul;
    logic start;
    logic update;
  } pfd_cmd_t;

  typedef struct packed {
    logic div_busy;
  } pfd_status_t;

endpackage

// ----- rtl/pi_fan_drive_antiwindup_unit.sv -----
// Top level of the PI fan drive controller with conditional-integration anti-windup.
// Each request carries one measured temperature and yields one fan drive value with its
// clamp flag. One request is in work at a time: once accepted it passes through the
// multiply, divider start, divider wait and update states to the result register, and
// no new request is taken before it is back in idle. The wait is set by the 24-step
// serial divider that forms the scaled error divided by the integral divisor, while the
// integral divided by 255 comes from a reciprocal multiply. A finished result waits in
// the output register while the next request is already accepted.
module pi_fan_drive_antiwindup_unit import pfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] measured_temp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DRIVE_W-1:0]       fan_drive,
  output logic                     clamped
);

  pfd_cmd_t    cmd;
  pfd_status_t status;

  pfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pfd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .measured_temp (measured_temp),
    .cmd           (cmd),
    .status        (status),
    .fan_drive     (fan_drive),
    .clamped       (clamped)
  );

endmodule

// ----- rtl/pfd_divider.sv -----
// Serial restoring divider: unsigned 24-bit dividend by an 8-bit divisor, one bit a cycle.
module pfd_divider import pfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [INTEG_W-1:0] dividend,
  input  logic [IDIV_W-1:0]  divisor,
  output logic               busy,
  output logic [INTEG_W-1:0] quotient
);

  logic [IDIV_W-1:0]    rem;
  logic [IDIV_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [IDIV_W:0]      trial;
  logic                 fits;

  assign trial = {rem, quotient[INTEG_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? IDIV_W'(trial - {1'b0, dsr}) : trial[IDIV_W-1:0];
      quotient <= {quotient[INTEG_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/pfd_datapath.sv -----
// Datapath: configuration registers, error multiplier, integral scaling, divider and update.
module pfd_datapath import pfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [TEMP_W-1:0] measured_temp,
  input  pfd_cmd_t                 cmd,
  output pfd_status_t              status,
  output logic [DRIVE_W-1:0]       fan_drive,
  output logic                     clamped
);

  logic signed [SETP_W-1:0]  setpoint;
  logic [GAIN_W-1:0]         prop_gain;
  logic [IDIV_W-1:0]         integral_divisor;
  logic signed [INTEG_W-1:0] integral_sum;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [INTEG_W-1:0] scaled;
  logic                      int_neg;
  logic                      err_neg;

  logic signed [SUM_W-1:0]   product;
  logic [INTEG_W-1:0]        int_mag;
  logic [INTEG_W+RECIP_W-1:0] int_prod;
  logic [INTEG_W-1:0]        err_mag;
  logic [IDIV_W-1:0]         err_div;
  logic [INTEG_W-1:0]        quo_int;
  logic [INTEG_W-1:0]        quo_err;
  logic                      busy_err;
  logic signed [SUM_W-1:0]   q_int;
  logic signed [SUM_W-1:0]   q_err;
  logic signed [SUM_W-1:0]   drive;
  logic signed [SUM_W-1:0]   integ_raw;
  logic signed [INTEG_W-1:0] integral_sum_next;
  logic                      clip;
  logic [DRIVE_W-1:0]        drive_sat;

  assign product  = diff * $signed({1'b0, prop_gain});
  assign int_mag  = integral_sum[INTEG_W-1] ? INTEG_W'(-integral_sum) : integral_sum;
  assign int_prod = int_mag * INTEG_RECIP;
  assign err_mag  = scaled[INTEG_W-1] ? INTEG_W'(-scaled) : scaled;
  assign err_div  = (integral_divisor == '0) ? IDIV_W'(1) : integral_divisor;

  pfd_divider u_div_err (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (err_mag),
    .divisor  (err_div),
    .busy     (busy_err),
    .quotient (quo_err)
  );

  assign status.div_busy = busy_err;

  always_comb begin
    q_int     = int_neg ? -$signed({1'b0, quo_int}) : $signed({1'b0, quo_int});
    q_err     = err_neg ? -$signed({1'b0, quo_err}) : $signed({1'b0, quo_err});
    drive     = {scaled[INTEG_W-1], scaled} + q_int;
    integ_raw = {integral_sum[INTEG_W-1], integral_sum} + q_err;
    clip      = (drive < 0) || (drive > DRIVE_MAX);
    priority if (drive < 0) begin
      drive_sat = '0;
    end else if (drive > DRIVE_MAX) begin
      drive_sat = '1;
    end else begin
      drive_sat = drive[DRIVE_W-1:0];
    end
    priority if (integ_raw > INTEG_HIGH) begin
      integral_sum_next = INTEG_HIGH[INTEG_W-1:0];
    end else if (integ_raw < INTEG_LOW) begin
      integral_sum_next = INTEG_LOW[INTEG_W-1:0];
    end else begin
      integral_sum_next = integ_raw[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint         <= SETPOINT_RESET;
      prop_gain        <= PROP_GAIN_RESET;
      integral_divisor <= INTEGRAL_DIVISOR_RESET;
      integral_sum     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SETPOINT:         setpoint         <= cfg_data;
          REG_PROP_GAIN:        prop_gain        <= cfg_data[GAIN_W-1:0];
          REG_INTEGRAL_DIVISOR: integral_divisor <= cfg_data[IDIV_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update && !clip) begin
        integral_sum <= integral_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff <= DIFF_W'(measured_temp) - DIFF_W'(setpoint);
    end
    if (cmd.mul) begin
      scaled <= product[INTEG_W-1:0];
    end
    if (cmd.start) begin
      int_neg <= integral_sum[INTEG_W-1];
      err_neg <= scaled[INTEG_W-1];
      quo_int <= INTEG_W'(int_prod[INTEG_W+RECIP_W-1:RECIP_SHIFT]);
    end
    if (cmd.update) begin
      fan_drive <= diff[DIFF_W-1] ? '0 : drive_sat;
      clamped   <= clip;
    end
  end

endmodule

// ----- rtl/pfd_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
module pfd_ctrl import pfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  pfd_status_t status,
  output pfd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_WAIT,
    S_UPDATE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.mul    = (state == S_MUL);
    cmd.start  = (state == S_START);
    cmd.update = (state == S_UPDATE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_UPDATE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (!status.div_busy) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pfd_checker.sv -----
// Port-level checker for the fan drive block, bound to the top level.
`include "pi_fan_drive_antiwindup_unit_macros.svh"

module pfd_checker import pfd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_write,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [CFG_DATA_W-1:0]    cfg_data,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic signed [TEMP_W-1:0] measured_temp,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [DRIVE_W-1:0]       fan_drive,
  input logic                     clamped
);

  // A stalled result holds its value.
  `PFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({fan_drive, clamped}))

  // Only one request is in work, so an accepted request closes the input.
  `PFD_ASSERT_NEXT(a_one_in_work, in_valid && !in_stall, in_stall)

  // A clamped drive sits at one of the two rails.
  `PFD_ASSERT_SAME(a_clamp_rail, out_valid && clamped, fan_drive == '0 || fan_drive == '1)

  // No result appears in the cycle right after a request is taken.
  `PFD_ASSERT_NEXT(a_no_early_out, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind pi_fan_drive_antiwindup_unit pfd_checker u_pfd_checker (.*);

// ----- tb/sv/pi_fan_drive_antiwindup_unit_tb.sv -----
// Self-checking testbench for the PI fan drive controller with anti-windup.
module pi_fan_drive_antiwindup_unit_tb;
  import pfd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 225;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               clip;
  } fan_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] measured_temp = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DRIVE_W-1:0]       fan_drive;
  logic                     clamped;

  logic signed [TEMP_W-1:0] pending_temps[$];
  fan_result_t              expected_drives[$];
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  int                       mismatches = 0;
  int                       cycle_count = 0;

  logic signed [SETP_W-1:0] ctl_setpoint = SETPOINT_RESET;
  logic [GAIN_W-1:0]        ctl_gain = PROP_GAIN_RESET;
  logic [IDIV_W-1:0]        ctl_divisor = INTEGRAL_DIVISOR_RESET;
  longint                   integ_acc = 0;

  pi_fan_drive_antiwindup_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .measured_temp(measured_temp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fan_drive(fan_drive),
    .clamped(clamped)
  );

  always #1 clk = ~clk;

  function automatic fan_result_t next_fan_drive(input logic signed [TEMP_W-1:0] temp);
    longint err_scaled;
    longint drive;
    longint step_div;
    longint nxt;
    fan_result_t r;
    err_scaled = (longint'(temp) - longint'(ctl_setpoint)) * longint'(ctl_gain);
    drive = err_scaled + integ_acc / longint'(INTEG_DIV);
    r.clip = 1'b0;
    if (drive < 0) begin
      drive = 0;
      r.clip = 1'b1;
    end else if (drive > longint'(DRIVE_MAX)) begin
      drive = longint'(DRIVE_MAX);
      r.clip = 1'b1;
    end else begin
      step_div = (ctl_divisor == '0) ? 64'sd1 : longint'(ctl_divisor);
      nxt = integ_acc + err_scaled / step_div;
      if (nxt > longint'(INTEG_HIGH)) nxt = longint'(INTEG_HIGH);
      if (nxt < longint'(INTEG_LOW)) nxt = longint'(INTEG_LOW);
      integ_acc = nxt;
    end
    if (longint'(ctl_setpoint) > longint'(temp)) drive = 0;
    r.drive = drive[DRIVE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int w;
    int v;
    int sel;
    sel = int'($urandom_range(0, 99));
    if (sel < 70) begin
      w = (ctl_gain == '0) ? 40 : 320 / int'(ctl_gain) + 4;
      v = int'(ctl_setpoint) + int'($urandom_range(0, 2 * w)) - w;
      if (v > 16383) v = 16383;
      if (v < -16384) v = -16384;
    end else if (sel < 85) begin
      v = int'($urandom_range(0, 32767)) - 16384;
    end else begin
      v = int'($urandom_range(0, 18000)) - 5500;
    end
    return v[TEMP_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SETPOINT: ctl_setpoint = data;
      REG_PROP_GAIN: ctl_gain = data[GAIN_W-1:0];
      REG_INTEGRAL_DIVISOR: ctl_divisor = data[IDIV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int sp, input int gain, input int divisor);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
    write_reg(REG_PROP_GAIN, {junk[CFG_DATA_W-1:GAIN_W], GAIN_W'(gain)});
    write_reg(REG_INTEGRAL_DIVISOR, {junk[CFG_DATA_W-1:IDIV_W], IDIV_W'(divisor)});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_temps.size() != 0 || in_valid || expected_drives.size() != 0);
  endtask

  // Half the items are sent, then the sender holds off until the block is empty.
  task automatic run_random(input int n);
    for (int i = 0; i < n / 2; i++) pending_temps.push_back(pick_temp());
    wait_drained();
    for (int i = n / 2; i < n; i++) pending_temps.push_back(pick_temp());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_drives.push_back(next_fan_drive(measured_temp));
      if (!in_valid || !in_stall) begin
        if (pending_temps.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          measured_temp <= pending_temps.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: fan_drive %0d clamped %0b", fan_drive, clamped);
        end else begin
          fan_result_t exp_r;
          exp_r = expected_drives.pop_front();
          if (fan_drive !== exp_r.drive || clamped !== exp_r.clip) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: fan_drive %0d clamped %0b, expected %0d and %0b",
                       fan_drive, clamped, exp_r.drive, exp_r.clip);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int send_modes[4];
    int recv_modes[4];
    int sp;
    int gain;
    int divisor;
    send_modes = '{0, 67, 0, 10};
    recv_modes = '{0, 0, 67, 10};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset settings: extremes, equality and small errors.
    pending_temps = '{-16384, 16383, -5500, 12500, 0, -1, 2299, 2300, 2301, 2400, 2427, 2428};
    wait_drained();
    // Zero divisor treated as one, with errors small enough to integrate.
    configure(1000, 1, 0);
    pending_temps = '{1050, 1100, 1200, 900, 16383, -16384};
    wait_drained();
    // Extreme setpoint below every measurement, largest gain.
    configure(-32768, 127, 255);
    pending_temps = '{16383, -16384};
    wait_drained();
    // Extreme setpoint above every measurement: the drive is forced off.
    configure(32767, 0, 1);
    pending_temps = '{16383, 0, -16384};
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sp = int'($urandom_range(0, 18000)) - 5500;
      gain = int'($urandom_range(1, 127));
      divisor = int'($urandom_range(0, 255));
      if (p == 0) begin
        gain = 127;
        divisor = 255;
      end else if (p == 1) begin
        gain = 1;
        divisor = 0;
      end else if (p == 2) begin
        divisor = 1;
      end
      configure(sp, gain, divisor);
      send_idle_pct = send_modes[p % 4];
      recv_stall_pct = recv_modes[p % 4];
      run_random(PHASE_ITEMS);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
